>>> rtl/mecs_pkg.sv
// shared types and constants of the min-eigenvalue corner score block
package mecs_pkg;

	localparam int GRAD_BITS  = 16;
	localparam int PROD_W     = 2 * GRAD_BITS;      // signed gradient product
	localparam int PSQ_W      = 2 * GRAD_BITS - 1;  // nonnegative square
	localparam int SQ_W       = 41;                 // sum of squares
	localparam int XY_W       = 42;                 // signed cross sum
	localparam int TRACE_W    = 42;
	localparam int HALF_W     = 21;                 // operand half for partial products
	localparam int PART_W     = 2 * HALF_W;
	localparam int RAD_W      = 86;                 // radicand width, even
	localparam int ROOT_W     = RAD_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int PART_CNT   = 6;
	localparam int STEP_W     = 3;
	localparam int CNT_W      = 6;
	localparam int SCORE_W    = 31;
	localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(1) << 30;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic        [SQ_W-1:0] sum_xx;
		logic        [SQ_W-1:0] sum_yy;
		logic signed [XY_W-1:0] sum_xy;
	} sums_t;

endpackage

>>> rtl/mecs_front.sv
// front end: squares the gradients and accumulates the window sums
module mecs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic signed [mecs_pkg::GRAD_BITS-1:0] grad_x,
	input  logic signed [mecs_pkg::GRAD_BITS-1:0] grad_y,
	input  logic                          last_sample,
	input  logic                          q_full,
	output logic                          q_push,
	output mecs_pkg::sums_t               push_sums
);
	import mecs_pkg::*;

	logic                     v_s1;
	logic                     last_s1;
	logic        [PSQ_W-1:0]  pxx_s1;
	logic        [PSQ_W-1:0]  pyy_s1;
	logic signed [PROD_W-1:0] pxy_s1;
	logic signed [PROD_W-1:0] sq_x, sq_y, prod_xy;

	logic        [SQ_W-1:0]   sum_xx_q, sum_yy_q;
	logic signed [XY_W-1:0]   sum_xy_q;
	logic        [SQ_W:0]     xx_ext, yy_ext;
	logic signed [XY_W:0]     xy_ext;
	sums_t                    next_sums;
	logic                     adv;

	assign sq_x    = grad_x * grad_x;
	assign sq_y    = grad_y * grad_y;
	assign prod_xy = grad_x * grad_y;

	// a last sample waits in s1 while the queue is full
	assign adv          = v_s1 && (!last_s1 || !q_full);
	assign sample_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (sample_ready) begin
			v_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			last_s1 <= last_sample;
			pxx_s1  <= sq_x[PSQ_W-1:0];
			pyy_s1  <= sq_y[PSQ_W-1:0];
			pxy_s1  <= prod_xy;
		end
	end

	// saturating accumulate
	always_comb begin
		xx_ext = {1'b0, sum_xx_q} + {{(SQ_W+1-PSQ_W){1'b0}}, pxx_s1};
		yy_ext = {1'b0, sum_yy_q} + {{(SQ_W+1-PSQ_W){1'b0}}, pyy_s1};
		xy_ext = {sum_xy_q[XY_W-1], sum_xy_q}
			+ {{(XY_W+1-PROD_W){pxy_s1[PROD_W-1]}}, pxy_s1};
		next_sums.sum_xx = xx_ext[SQ_W] ? {SQ_W{1'b1}} : xx_ext[SQ_W-1:0];
		next_sums.sum_yy = yy_ext[SQ_W] ? {SQ_W{1'b1}} : yy_ext[SQ_W-1:0];
		if (xy_ext[XY_W] != xy_ext[XY_W-1]) begin
			next_sums.sum_xy = xy_ext[XY_W] ? {1'b1, {(XY_W-1){1'b0}}}
				: {1'b0, {(XY_W-1){1'b1}}};
		end else begin
			next_sums.sum_xy = xy_ext[XY_W-1:0];
		end
	end

	assign q_push    = adv && last_s1;
	assign push_sums = next_sums;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				sum_xx_q <= '0;
				sum_yy_q <= '0;
				sum_xy_q <= '0;
			end else begin
				sum_xx_q <= next_sums.sum_xx;
				sum_yy_q <= next_sums.sum_yy;
				sum_xy_q <= next_sums.sum_xy;
			end
		end
	end

endmodule

>>> rtl/mecs_queue.sv
// two-entry queue of finished window sums
module mecs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  mecs_pkg::sums_t     wr_sums,
	output mecs_pkg::sums_t     rd_sums,
	input  logic                push,
	input  logic                pop,
	output logic                full,
	output logic                empty
);
	import mecs_pkg::*;

	sums_t       slot_q [QUEUE_DEPTH];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;

	assign full    = (count_q == 2'(QUEUE_DEPTH));
	assign empty   = (count_q == 2'd0);
	assign rd_sums = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= wr_sums;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/mecs_back.sv
// back end: radicand by partial products, digit-recurrence square root, score
module mecs_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mecs_pkg::sums_t                   rd_sums,
	input  logic                              q_empty,
	output logic                              q_pop,
	output logic                              score_valid,
	input  logic                              score_ready,
	output logic [mecs_pkg::SCORE_W-1:0]      corner_score
);
	import mecs_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_ROOT,
		S_SCORE
	} state_t;

	state_t                state_q;
	logic [STEP_W-1:0]     step_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TRACE_W-1:0]    trace_q;
	logic [PART_W-1:0]     d_q;
	logic [PART_W-1:0]     x_q;
	logic [PART_W-1:0]     prod_q;
	logic [CNT_W-1:0]      shift_q;
	logic [RAD_W-1:0]      rad_q;
	logic [REM_W-1:0]      rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic                  score_valid_q;
	logic [SCORE_W-1:0]    score_q;

	logic [HALF_W-1:0]     op_a, op_b;
	logic [CNT_W-1:0]      op_shift;
	logic [PART_W-1:0]     part;
	logic [SQ_W-1:0]       diff;
	logic [XY_W-1:0]       mag;
	logic [REM_W+1:0]      rem_ext, trial;
	logic [TRACE_W-1:0]    gap;
	logic [SCORE_W-1:0]    score_next;
	logic                  out_free;

	// absolute difference of the diagonal sums and magnitude of the cross sum
	assign diff = (rd_sums.sum_xx >= rd_sums.sum_yy) ? rd_sums.sum_xx - rd_sums.sum_yy
		: rd_sums.sum_yy - rd_sums.sum_xx;
	assign mag  = rd_sums.sum_xy[XY_W-1] ? XY_W'(-rd_sums.sum_xy) : rd_sums.sum_xy;

	// partial products: d*d then 4*x*x, each operand split into two halves
	always_comb begin
		case (step_q)
			3'd0: begin op_a = d_q[HALF_W-1:0];      op_b = d_q[HALF_W-1:0];
				op_shift = 6'd0; end
			3'd1: begin op_a = d_q[HALF_W-1:0];      op_b = d_q[PART_W-1:HALF_W];
				op_shift = 6'(HALF_W + 1); end
			3'd2: begin op_a = d_q[PART_W-1:HALF_W]; op_b = d_q[PART_W-1:HALF_W];
				op_shift = 6'(2 * HALF_W); end
			3'd3: begin op_a = x_q[HALF_W-1:0];      op_b = x_q[HALF_W-1:0];
				op_shift = 6'd2; end
			3'd4: begin op_a = x_q[HALF_W-1:0];      op_b = x_q[PART_W-1:HALF_W];
				op_shift = 6'(HALF_W + 3); end
			3'd5: begin op_a = x_q[PART_W-1:HALF_W]; op_b = x_q[PART_W-1:HALF_W];
				op_shift = 6'(2 * HALF_W + 2); end
			default: begin op_a = '0; op_b = '0; op_shift = '0; end
		endcase
	end
	assign part = op_a * op_b;

	// one root digit per cycle
	assign rem_ext = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};

	// final score with the floor at zero and the ceiling at 2^30
	always_comb begin
		gap = trace_q - root_q[TRACE_W-1:0];
		if ({1'b0, trace_q} <= root_q) begin
			score_next = '0;
		end else if (gap > TRACE_W'(SCORE_MAX)) begin
			score_next = SCORE_MAX;
		end else begin
			score_next = gap[SCORE_W-1:0];
		end
	end

	assign out_free     = !score_valid_q || score_ready;
	assign q_pop        = (state_q == S_IDLE) && !q_empty;
	assign score_valid  = score_valid_q;
	assign corner_score = score_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			step_q        <= '0;
			cnt_q         <= '0;
			score_valid_q <= 1'b0;
			score_q       <= '0;
		end else begin
			// a new score refills the output register in the cycle the old one leaves
			if ((state_q == S_SCORE) && out_free) begin
				score_valid_q <= 1'b1;
			end else if (score_valid_q && score_ready) begin
				score_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= S_MUL;
						step_q  <= '0;
					end
				end
				S_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == STEP_W'(PART_CNT)) begin
						state_q <= S_ROOT;
						cnt_q   <= '0;
					end
				end
				S_ROOT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == CNT_W'(ROOT_W - 1)) begin
						state_q <= S_SCORE;
					end
				end
				S_SCORE: begin
					if (out_free) begin
						score_q <= score_next;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				trace_q <= {1'b0, rd_sums.sum_xx} + {1'b0, rd_sums.sum_yy};
				d_q     <= {1'b0, diff};
				x_q     <= mag;
				rad_q   <= '0;
				rem_q   <= '0;
				root_q  <= '0;
			end
			S_MUL: begin
				prod_q  <= part;
				shift_q <= op_shift;
				if (step_q != '0) begin
					rad_q <= rad_q + (RAD_W'(prod_q) << shift_q);
				end
			end
			S_ROOT: begin
				rad_q <= rad_q << 2;
				if (rem_ext >= trial) begin
					rem_q  <= REM_W'(rem_ext - trial);
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= REM_W'(rem_ext);
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/min_eigenvalue_corner_score.sv
// top level of the min-eigenvalue (shi-tomasi) corner score block
//
//  channel   handshake                     payload
//  sample    sample_valid / sample_ready   grad_x, grad_y, last_sample
//  score     score_valid / score_ready     corner_score
//
// samples are taken one per cycle unless a last sample stalls on a full queue;
// squaring sits in s1, the sums update after it; the score unit takes one window
// at a time: six partial products on one 21x21 multiplier, then a 43-step
// bit-serial square root; a two-entry queue holds finished window sums, so short
// windows stall only when two sums wait and the score unit is busy
// reset clears the sums, the queue and the score unit; no clearing pass
// the score sits in an output register, and the next window starts meanwhile
module min_eigenvalue_corner_score (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  logic signed [mecs_pkg::GRAD_BITS-1:0] grad_x,
	input  logic signed [mecs_pkg::GRAD_BITS-1:0] grad_y,
	input  logic                                  last_sample,
	output logic                                  score_valid,
	input  logic                                  score_ready,
	output logic [mecs_pkg::SCORE_W-1:0]          corner_score
);
	import mecs_pkg::*;

	// sums of one finished window travel front -> queue -> back
	sums_t      push_sums;
	sums_t      rd_sums;
	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_empty;

	// front: squares and saturating accumulation at full sample rate
	mecs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.grad_x       (grad_x),
		.grad_y       (grad_y),
		.last_sample  (last_sample),
		.q_full       (q_full),
		.q_push       (q_push),
		.push_sums    (push_sums)
	);

	// decoupling queue between accumulation and the score unit
	mecs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_sums (push_sums),
		.rd_sums (rd_sums),
		.push    (q_push),
		.pop     (q_pop),
		.full    (q_full),
		.empty   (q_empty)
	);

	// back: radicand, square root and clamped score with output register
	mecs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_sums      (rd_sums),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.score_valid  (score_valid),
		.score_ready  (score_ready),
		.corner_score (corner_score)
	);

endmodule

>>> rtl/mecs_checker.sv
// port-level checker of the corner score block and its bind
module mecs_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	input  logic                                  sample_ready,
	input  logic signed [mecs_pkg::GRAD_BITS-1:0] grad_x,
	input  logic signed [mecs_pkg::GRAD_BITS-1:0] grad_y,
	input  logic                                  last_sample,
	input  logic                                  score_valid,
	input  logic                                  score_ready,
	input  logic [mecs_pkg::SCORE_W-1:0]          corner_score
);
	import mecs_pkg::*;

	// windows closed at the input but not yet delivered as a score
	logic [2:0] pending_q;
	logic       win_in, win_out;
	logic       gx_seen;

	assign win_in  = sample_valid && sample_ready && last_sample;
	assign win_out = score_valid && score_ready;
	assign gx_seen = ^{grad_x, grad_y} || 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({win_in, win_out})
				2'b10:   pending_q <= pending_q + 3'd1;
				2'b01:   pending_q <= pending_q - 3'd1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	a_score_hold: assert property (@(posedge clk) disable iff (!arst_n)
		score_valid && !score_ready |=> score_valid && $stable(corner_score))
		else $error("score changed or dropped while stalled");

	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		score_valid |-> corner_score <= SCORE_MAX)
		else $error("score above its ceiling");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		score_valid && gx_seen |-> pending_q != 3'd0)
		else $error("score without a closed window");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd5)
		else $error("more windows in flight than the block can hold");

endmodule

bind min_eigenvalue_corner_score mecs_checker u_mecs_checker (.*);
